// ===== hdl/bmal_pkg.sv =====
// Shared types, codes and word helpers for the bitmap allocator.
package bmal_pkg;

  localparam int WORD_W  = 8;
  localparam int FIELD_W = 14;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_ALLOC   = 2'd2,
    OP_RECOUNT = 2'd3
  } op_t;

  localparam logic CFG_ITEM_COUNT  = 1'b0;
  localparam logic CFG_FIRST_ALLOC = 1'b1;

  typedef struct packed {
    logic               bit_read;
    logic               found;
    logic [FIELD_W-1:0] allocated_number;
    logic [FIELD_W-1:0] free_running;
    logic [FIELD_W-1:0] free_counted;
    logic               range_error;
  } res_t;

  // number of set bits in one word
  function automatic logic [3:0] popcount8(input logic [WORD_W-1:0] w);
    logic [3:0] s;
    s = 4'd0;
    for (int k = 0; k < WORD_W; k++) begin
      s = s + {3'd0, w[k]};
    end
    return s;
  endfunction

  // lowest set bit: {hit, position}
  function automatic logic [3:0] first_one8(input logic [WORD_W-1:0] w);
    logic [3:0] r;
    r = 4'd0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (w[k]) begin
        r = {1'b1, 3'(k)};
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/bmal_mem.sv =====
// Bitmap word store: one write port, one read port, registered read data.
module bmal_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [bmal_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [bmal_pkg::WORD_W-1:0] rdata
);

  logic [bmal_pkg::WORD_W-1:0] mem [DEPTH];
  logic [bmal_pkg::WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/bmal_ctrl.sv =====
// Sequencer: clearing pass, read-modify-write, allocate and recount scans.
module bmal_ctrl #(
  parameter int BITS  = 8192,
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int NW    = 14
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode,
  input  logic [bmal_pkg::FIELD_W-1:0] item_number,
  input  logic                        new_bit,
  input  logic [NW-1:0]               eff_count,
  input  logic [NW-1:0]               first_num,
  // store port
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [bmal_pkg::WORD_W-1:0] mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [bmal_pkg::WORD_W-1:0] mem_rdata,
  // result
  output logic                        res_valid,
  output bmal_pkg::res_t              res
);

  localparam int CW = $clog2(BITS + 1);
  localparam logic [bmal_pkg::WORD_W-1:0] ALL1 = '1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_RMW   = 4'b0100,
    S_SCAN  = 4'b1000
  } state_t;

  state_t          state_r, state_nxt;
  bmal_pkg::op_t   op_r, op_nxt;
  logic            nb_r, nb_nxt;
  logic [AW-1:0]   addr_r, addr_nxt;     // clear / read pointer
  logic [AW-1:0]   da_r, da_nxt;         // word whose data is on mem_rdata
  logic            dv_r, dv_nxt;
  logic            done_r, done_nxt;     // all scan reads issued
  logic [AW-1:0]   startw_r, startw_nxt;
  logic [AW-1:0]   lastw_r, lastw_nxt;
  logic [2:0]      lo_r, lo_nxt;
  logic [2:0]      hi_r, hi_nxt;
  logic [2:0]      bsel_r, bsel_nxt;
  logic [CW-1:0]   free_r, free_nxt;
  logic [CW-1:0]   acc_r, acc_nxt;
  logic            out_valid_r, out_valid_nxt;
  bmal_pkg::res_t  out_r, out_nxt;

  logic [NW-1:0]   num_ext, idx_in, start_n, sidx, cidx;
  logic            range_bad, alloc_none;
  logic [bmal_pkg::WORD_W-1:0] mask, free_bits;
  logic [3:0]      ffo;
  logic [3:0]      pop;
  logic            cur_bit;
  logic [CW-1:0]   acc_sum;
  logic [NW-1:0]   alloc_num;

  always_comb begin
    num_ext    = NW'(item_number);
    idx_in     = num_ext - NW'(1);
    range_bad  = (num_ext == '0) || (num_ext > eff_count);
    start_n    = (first_num == '0) ? NW'(1) : first_num;
    sidx       = start_n - NW'(1);
    cidx       = eff_count - NW'(1);
    alloc_none = start_n > eff_count;

    mask = ALL1;
    if (da_r == startw_r) begin
      mask = mask & (ALL1 << lo_r);
    end
    if (da_r == lastw_r) begin
      mask = mask & (ALL1 >> (3'd7 - hi_r));
    end
    free_bits = ~mem_rdata & mask;
    ffo       = bmal_pkg::first_one8(free_bits);
    pop       = bmal_pkg::popcount8(free_bits);
    acc_sum   = acc_r + CW'(pop);
    alloc_num = NW'({da_r, ffo[2:0]}) + NW'(1);
    cur_bit   = mem_rdata[bsel_r];
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    nb_nxt        = nb_r;
    addr_nxt      = addr_r;
    da_nxt        = da_r;
    dv_nxt        = dv_r;
    done_nxt      = done_r;
    startw_nxt    = startw_r;
    lastw_nxt     = lastw_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    bsel_nxt      = bsel_r;
    free_nxt      = free_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + AW'(1);
        end
      end

      S_IDLE: begin
        if (start) begin
          op_nxt  = bmal_pkg::op_t'(opcode);
          nb_nxt  = new_bit;
          out_nxt = '0;
          out_nxt.free_running = bmal_pkg::FIELD_W'(free_r);
          unique case (bmal_pkg::op_t'(opcode))
            bmal_pkg::OP_READ, bmal_pkg::OP_WRITE: begin
              if (range_bad) begin
                out_valid_nxt       = 1'b1;
                out_nxt.range_error = 1'b1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = idx_in[AW+2:3];
                addr_nxt  = idx_in[AW+2:3];
                bsel_nxt  = idx_in[2:0];
                state_nxt = S_RMW;
              end
            end
            bmal_pkg::OP_ALLOC: begin
              if (alloc_none) begin
                out_valid_nxt = 1'b1;
              end else begin
                addr_nxt   = sidx[AW+2:3];
                startw_nxt = sidx[AW+2:3];
                lo_nxt     = sidx[2:0];
                lastw_nxt  = cidx[AW+2:3];
                hi_nxt     = cidx[2:0];
                dv_nxt     = 1'b0;
                done_nxt   = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
            bmal_pkg::OP_RECOUNT: begin
              if (eff_count == '0) begin
                out_valid_nxt = 1'b1;
              end else begin
                addr_nxt   = '0;
                startw_nxt = '0;
                lo_nxt     = 3'd0;
                lastw_nxt  = cidx[AW+2:3];
                hi_nxt     = cidx[2:0];
                acc_nxt    = '0;
                dv_nxt     = 1'b0;
                done_nxt   = 1'b0;
                state_nxt  = S_SCAN;
              end
            end
          endcase
        end
      end

      S_RMW: begin
        out_valid_nxt    = 1'b1;
        out_nxt.bit_read = cur_bit;
        mem_waddr        = addr_r;
        mem_wdata        = mem_rdata;
        mem_wdata[bsel_r] = nb_r;
        if (op_r == bmal_pkg::OP_WRITE && nb_r != cur_bit) begin
          mem_we   = 1'b1;
          free_nxt = nb_r ? free_r - CW'(1) : free_r + CW'(1);
        end
        out_nxt.free_running = bmal_pkg::FIELD_W'(free_nxt);
        state_nxt = S_IDLE;
      end

      S_SCAN: begin
        // keep one read in flight ahead of the word being examined
        if (!done_r) begin
          mem_re    = 1'b1;
          mem_raddr = addr_r;
          dv_nxt    = 1'b1;
          da_nxt    = addr_r;
          if (addr_r == lastw_r) begin
            done_nxt = 1'b1;
          end else begin
            addr_nxt = addr_r + AW'(1);
          end
        end else begin
          dv_nxt = 1'b0;
        end

        if (dv_r) begin
          if (op_r == bmal_pkg::OP_ALLOC) begin
            if (ffo[3]) begin
              mem_we    = 1'b1;
              mem_waddr = da_r;
              mem_wdata = mem_rdata | (bmal_pkg::WORD_W'(1) << ffo[2:0]);
              free_nxt  = free_r - CW'(1);
              out_valid_nxt            = 1'b1;
              out_nxt.found            = 1'b1;
              out_nxt.allocated_number = bmal_pkg::FIELD_W'(alloc_num);
              out_nxt.free_running     = bmal_pkg::FIELD_W'(free_nxt);
              dv_nxt    = 1'b0;
              state_nxt = S_IDLE;
            end else if (da_r == lastw_r) begin
              out_valid_nxt = 1'b1;
              dv_nxt        = 1'b0;
              state_nxt     = S_IDLE;
            end
          end else begin
            acc_nxt = acc_sum;
            if (da_r == lastw_r) begin
              out_valid_nxt        = 1'b1;
              out_nxt.free_counted = bmal_pkg::FIELD_W'(acc_sum);
              dv_nxt               = 1'b0;
              state_nxt            = S_IDLE;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      dv_r        <= 1'b0;
      done_r      <= 1'b0;
      free_r      <= CW'(BITS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      dv_r        <= dv_nxt;
      done_r      <= done_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    nb_r     <= nb_nxt;
    da_r     <= da_nxt;
    startw_r <= startw_nxt;
    lastw_r  <= lastw_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    bsel_r   <= bsel_nxt;
    acc_r    <= acc_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign res_valid = out_valid_r;
  assign res       = out_r;

endmodule

// ===== hdl/bitmap_allocator.sv =====
// Top level of the bitmap allocator: configuration registers, store and sequencer.
//
//  channel | ports                                   | transfer
//  --------+-----------------------------------------+--------------------------
//  input   | start, busy, in_opcode/item_number/...  | start high while busy low
//  result  | out_valid, out_*                        | out_valid, one cycle only
//  config  | cfg_we, cfg_index, cfg_wdata            | cfg_we high, no wait
//
// Read and write read the word from the store, then modify and write it back;
// an out-of-range number answers the cycle after accept.
// Allocate and recount scan one 8-bit word per cycle through the single
// read port.
// After reset a clearing pass writes every word of the store, with busy high.
// Results cannot be held off.
module bitmap_allocator #(
  parameter int BITS = 8192
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [1:0]                   in_opcode,
  input  logic [bmal_pkg::FIELD_W-1:0] in_item_number,
  input  logic                         in_new_bit,
  output logic                         out_valid,
  output logic                         out_bit_read,
  output logic                         out_found,
  output logic [bmal_pkg::FIELD_W-1:0] out_allocated_number,
  output logic [bmal_pkg::FIELD_W-1:0] out_free_running,
  output logic [bmal_pkg::FIELD_W-1:0] out_free_counted,
  output logic                         out_range_error,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bmal_pkg::FIELD_W-1:0] cfg_wdata
);

  localparam int DEPTH = (BITS + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(BITS + 1);
  localparam int NW    = (CW > bmal_pkg::FIELD_W) ? CW : bmal_pkg::FIELD_W;

  logic [bmal_pkg::FIELD_W-1:0] item_count_r, item_count_nxt;
  logic [bmal_pkg::FIELD_W-1:0] first_r, first_nxt;
  logic [NW-1:0]                cnt_ext, eff_count;

  logic                         mem_we, mem_re;
  logic [AW-1:0]                mem_waddr, mem_raddr;
  logic [bmal_pkg::WORD_W-1:0]  mem_wdata, mem_rdata;
  logic                         res_valid;
  bmal_pkg::res_t               res;

  // config writes
  always_comb begin
    item_count_nxt = item_count_r;
    first_nxt      = first_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bmal_pkg::CFG_ITEM_COUNT:  item_count_nxt = cfg_wdata;
        bmal_pkg::CFG_FIRST_ALLOC: first_nxt      = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_count_r <= bmal_pkg::FIELD_W'(8192);
      first_r      <= bmal_pkg::FIELD_W'(1);
    end else begin
      item_count_r <= item_count_nxt;
      first_r      <= first_nxt;
    end
  end

  // item count above the store size is capped
  assign cnt_ext   = NW'(item_count_r);
  assign eff_count = (cnt_ext > NW'(BITS)) ? NW'(BITS) : cnt_ext;

  bmal_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bmal_ctrl #(
    .BITS  (BITS),
    .DEPTH (DEPTH),
    .AW    (AW),
    .NW    (NW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .opcode      (in_opcode),
    .item_number (in_item_number),
    .new_bit     (in_new_bit),
    .eff_count   (eff_count),
    .first_num   (NW'(first_r)),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata),
    .res_valid   (res_valid),
    .res         (res)
  );

  assign out_valid            = res_valid;
  assign out_bit_read         = res.bit_read;
  assign out_found            = res.found;
  assign out_allocated_number = res.allocated_number;
  assign out_free_running     = res.free_running;
  assign out_free_counted     = res.free_counted;
  assign out_range_error      = res.range_error;

endmodule

// ===== hdl/bmal_checker.sv =====
// Port-level checks for the bitmap allocator and their bind.
module bmal_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_valid,
  input logic                         out_bit_read,
  input logic                         out_found,
  input logic [bmal_pkg::FIELD_W-1:0] out_allocated_number,
  input logic [bmal_pkg::FIELD_W-1:0] out_free_counted,
  input logic                         out_range_error
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result without a transfer or work in progress");

  a_range_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_range_error) |->
      (!out_found && !out_bit_read && out_allocated_number == '0 &&
       out_free_counted == '0))
    else $error("range error result carries data");

  a_found_number: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_found == (out_allocated_number != '0)))
    else $error("found flag and allocated number disagree");

endmodule

bind bitmap_allocator bmal_checker u_bmal_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .start                (start),
  .busy                 (busy),
  .out_valid            (out_valid),
  .out_bit_read         (out_bit_read),
  .out_found            (out_found),
  .out_allocated_number (out_allocated_number),
  .out_free_counted     (out_free_counted),
  .out_range_error      (out_range_error)
);

// ===== bench/bitmap_allocator_tb.sv =====
// Self-checking testbench for the bitmap allocator: bit model, request driver, result checker.
`timescale 1ns / 100ps

module bitmap_allocator_tb;

  localparam int BITS = 8192;
  // Worst case per request: a full scan of BITS/8 words plus overhead and the longest
  // sender gap. Reckoned for ~900 requests, then taken a few times over.
  localparam int SCAN_CYCLES  = BITS / 8 + 16;
  localparam int CYCLE_LIMIT  = 3 * 900 * (SCAN_CYCLES + 10) + 4 * BITS;
  localparam int PHASE_ITEMS  = 85;
  localparam int PHASE_COUNT  = 10;

  // Shadow copy of the allocator: bit per item, running free counter and the two
  // registers. Every accepted request yields exactly one predicted result.
  class alloc_shadow;
    bit                           used_map [BITS+1];  // index is the one-based item number
    int unsigned                  free_cnt;
    logic [bmal_pkg::FIELD_W-1:0] item_count;
    logic [bmal_pkg::FIELD_W-1:0] first_alloc;
    bmal_pkg::res_t               due_results [$];
    int                           errors;

    function new();
      foreach (used_map[n]) used_map[n] = 1'b0;
      free_cnt    = BITS;
      item_count  = 14'd8192;
      first_alloc = 14'd1;
      errors      = 0;
    endfunction

    function void set_reg(input logic idx, input logic [bmal_pkg::FIELD_W-1:0] val);
      if (idx == bmal_pkg::CFG_ITEM_COUNT) item_count = val;
      else first_alloc = val;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // predict the result of one accepted request and advance the shadow state
    function void note_request(input bmal_pkg::op_t op,
                               input logic [bmal_pkg::FIELD_W-1:0] num,
                               input logic nb);
      bmal_pkg::res_t r;
      int unsigned    lim;
      int unsigned    lo;
      int unsigned    tally;
      bit             hit;
      r   = '0;
      lim = (item_count > BITS) ? BITS : item_count;
      case (op)
        bmal_pkg::OP_READ, bmal_pkg::OP_WRITE: begin
          if (num < 1 || num > lim) begin
            r.range_error = 1'b1;
          end else begin
            r.bit_read = used_map[num];
            if (op == bmal_pkg::OP_WRITE && used_map[num] != nb) begin
              used_map[num] = nb;
              if (nb) free_cnt--;
              else free_cnt++;
            end
          end
        end
        bmal_pkg::OP_ALLOC: begin
          lo  = (first_alloc == 0) ? 1 : first_alloc;
          hit = 1'b0;
          for (int unsigned n = lo; n <= lim; n++) begin
            if (!hit && !used_map[n]) begin
              used_map[n]        = 1'b1;
              free_cnt--;
              hit                = 1'b1;
              r.found            = 1'b1;
              r.allocated_number = bmal_pkg::FIELD_W'(n);
            end
          end
        end
        default: begin
          tally = 0;
          for (int unsigned n = 1; n <= lim; n++) begin
            if (!used_map[n]) tally++;
          end
          r.free_counted = bmal_pkg::FIELD_W'(tally);
        end
      endcase
      r.free_running = bmal_pkg::FIELD_W'(free_cnt);
      due_results.push_back(r);
    endfunction

    function void check_field(input string name,
                              input logic [bmal_pkg::FIELD_W-1:0] exp_v,
                              input logic [bmal_pkg::FIELD_W-1:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(input bmal_pkg::res_t got);
      bmal_pkg::res_t want;
      if (due_results.size() == 0) begin
        $error("result transfer with no request outstanding");
        errors++;
        return;
      end
      want = due_results.pop_front();
      check_field("bit_read", bmal_pkg::FIELD_W'(want.bit_read),
                  bmal_pkg::FIELD_W'(got.bit_read));
      check_field("found", bmal_pkg::FIELD_W'(want.found), bmal_pkg::FIELD_W'(got.found));
      check_field("allocated_number", want.allocated_number, got.allocated_number);
      check_field("free_running", want.free_running, got.free_running);
      check_field("free_counted", want.free_counted, got.free_counted);
      check_field("range_error", bmal_pkg::FIELD_W'(want.range_error),
                  bmal_pkg::FIELD_W'(got.range_error));
    endfunction
  endclass

  // ---------------------------------------------------------------- signals
  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic [1:0]                   in_opcode      = 2'd0;
  logic [bmal_pkg::FIELD_W-1:0] in_item_number = '0;
  logic                         in_new_bit     = 1'b0;
  logic                         out_valid;
  logic                         out_bit_read;
  logic                         out_found;
  logic [bmal_pkg::FIELD_W-1:0] out_allocated_number;
  logic [bmal_pkg::FIELD_W-1:0] out_free_running;
  logic [bmal_pkg::FIELD_W-1:0] out_free_counted;
  logic                         out_range_error;
  logic                         cfg_we         = 1'b0;
  logic                         cfg_index      = 1'b0;
  logic [bmal_pkg::FIELD_W-1:0] cfg_wdata      = '0;

  alloc_shadow shadow = new();
  int          gap_pct = 20;   // chance (percent) of a sender gap after each transfer
  int unsigned cycle_cnt = 0;

  always #5 clk = ~clk;

  bitmap_allocator #(.BITS(BITS)) i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_opcode           (in_opcode),
    .in_item_number      (in_item_number),
    .in_new_bit          (in_new_bit),
    .out_valid           (out_valid),
    .out_bit_read        (out_bit_read),
    .out_found           (out_found),
    .out_allocated_number(out_allocated_number),
    .out_free_running    (out_free_running),
    .out_free_counted    (out_free_counted),
    .out_range_error     (out_range_error),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // Result side: the strobe lasts one cycle and cannot be stalled, so every edge
  // that sees out_valid high is a transfer. Values read here are the ones that
  // held during the cycle just ended.
  always @(posedge clk) begin
    bmal_pkg::res_t got;
    if (rst_n && out_valid) begin
      got.bit_read         = out_bit_read;
      got.found            = out_found;
      got.allocated_number = out_allocated_number;
      got.free_running     = out_free_running;
      got.free_counted     = out_free_counted;
      got.range_error      = out_range_error;
      shadow.check_result(got);
    end
  end

  // hang guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("bitmap_allocator_tb NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------- driver
  // Present one request and hold it until the block takes it (start high, busy
  // low at the edge). start stays high into the next request unless a gap is drawn.
  task automatic send_request(input bmal_pkg::op_t op,
                              input logic [bmal_pkg::FIELD_W-1:0] num,
                              input logic nb);
    int gap;
    start          <= 1'b1;
    in_opcode      <= op;
    in_item_number <= num;
    in_new_bit     <= nb;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    shadow.note_request(op, num, nb);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      gap = $urandom_range(1, 10);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender holds off until every predicted result has come back. Each request
  // yields a result, so the block is idle after that; a few spare cycles anyway.
  task automatic pause_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (shadow.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cfg_we stays high across back-to-back writes; set_config lowers it once
  task automatic cfg_write(input logic idx, input logic [bmal_pkg::FIELD_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    shadow.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [bmal_pkg::FIELD_W-1:0] count,
                            input logic [bmal_pkg::FIELD_W-1:0] first);
    cfg_write(bmal_pkg::CFG_ITEM_COUNT, count);
    cfg_write(bmal_pkg::CFG_FIRST_ALLOC, first);
    cfg_we <= 1'b0;
  endtask

  // Item numbers: mostly in range, some on the edges, some anywhere in 14 bits.
  function automatic logic [bmal_pkg::FIELD_W-1:0] pick_number(input int unsigned lim);
    int k;
    k = $urandom_range(0, 9);
    if (k < 7 && lim > 0) return bmal_pkg::FIELD_W'($urandom_range(1, lim));
    if (k == 7) begin
      case ($urandom_range(0, 2))
        0:       return '0;
        1:       return bmal_pkg::FIELD_W'(lim);
        default: return bmal_pkg::FIELD_W'(lim + 1);
      endcase
    end
    return bmal_pkg::FIELD_W'($urandom_range(0, 16383));
  endfunction

  // Random mix: writes and allocates fill and drain the map so allocate runs
  // into full maps, recount checks the map against the running counter.
  // Drain pauses only come in phases that also idle between transfers.
  task automatic random_phase(input int n_items,
                              input logic [bmal_pkg::FIELD_W-1:0] count);
    int unsigned   lim;
    int            w;
    bmal_pkg::op_t op;
    lim = (count > BITS) ? BITS : count;
    for (int i = 0; i < n_items; i++) begin
      w = $urandom_range(0, 99);
      if (w < 25) op = bmal_pkg::OP_READ;
      else if (w < 60) op = bmal_pkg::OP_WRITE;
      else if (w < 90) op = bmal_pkg::OP_ALLOC;
      else op = bmal_pkg::OP_RECOUNT;
      send_request(op, pick_number(lim), 1'($urandom_range(0, 1)));
      if (gap_pct != 0 && $urandom_range(0, 39) == 0) pause_for_drain();
    end
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin : main_seq
    logic [bmal_pkg::FIELD_W-1:0] count;
    logic [bmal_pkg::FIELD_W-1:0] first;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // the clearing pass after reset runs with busy high
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);

    // directed: reset configuration, full map range
    send_request(bmal_pkg::OP_READ, 14'd1, 1'b0);
    send_request(bmal_pkg::OP_READ, 14'd0, 1'b0);          // below range
    send_request(bmal_pkg::OP_READ, 14'd8193, 1'b0);       // just above range
    send_request(bmal_pkg::OP_WRITE, 14'h3FFF, 1'b1);      // top of the field
    send_request(bmal_pkg::OP_WRITE, 14'd1, 1'b1);
    send_request(bmal_pkg::OP_WRITE, 14'd1, 1'b1);         // same bit again, counter holds
    send_request(bmal_pkg::OP_WRITE, 14'd8192, 1'b1);
    send_request(bmal_pkg::OP_ALLOC, 14'd0, 1'b0);
    send_request(bmal_pkg::OP_WRITE, 14'd1, 1'b0);
    send_request(bmal_pkg::OP_ALLOC, 14'h3FFF, 1'b1);
    send_request(bmal_pkg::OP_RECOUNT, 14'd0, 1'b0);

    // count above the map is capped, first number zero acts as one
    pause_for_drain();
    set_config(14'h3FFF, 14'd0);
    send_request(bmal_pkg::OP_ALLOC, 14'd0, 1'b0);
    send_request(bmal_pkg::OP_READ, 14'd8192, 1'b0);
    send_request(bmal_pkg::OP_READ, 14'd8193, 1'b0);

    // zero items: everything out of range, nothing to find or count
    pause_for_drain();
    set_config(14'd0, 14'd1);
    send_request(bmal_pkg::OP_READ, 14'd1, 1'b0);
    send_request(bmal_pkg::OP_ALLOC, 14'd0, 1'b0);
    send_request(bmal_pkg::OP_RECOUNT, 14'd0, 1'b0);

    // first number above the count
    pause_for_drain();
    set_config(14'd8, 14'd12);
    send_request(bmal_pkg::OP_ALLOC, 14'd0, 1'b0);

    // first number equal to the count, then nothing left above it
    pause_for_drain();
    set_config(14'd8, 14'd8);
    send_request(bmal_pkg::OP_ALLOC, 14'd0, 1'b0);
    send_request(bmal_pkg::OP_ALLOC, 14'd0, 1'b0);

    // fill the small range; free items remain above it (counter scope)
    pause_for_drain();
    set_config(14'd8, 14'd1);
    repeat (5) send_request(bmal_pkg::OP_ALLOC, 14'd0, 1'b0);
    send_request(bmal_pkg::OP_RECOUNT, 14'd0, 1'b0);
    pause_for_drain();

    // random phases; most use small counts so scans stay short
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0: begin
          count = 14'd8192;
          first = bmal_pkg::FIELD_W'($urandom_range(1, BITS));
        end
        1: begin
          count = 14'h3FFF;
          first = 14'h3FFF;
        end
        2: begin
          count = 14'd1;
          first = 14'd0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) count = bmal_pkg::FIELD_W'($urandom_range(41, 300));
          else count = bmal_pkg::FIELD_W'($urandom_range(2, 40));
          case ($urandom_range(0, 5))
            0:       first = '0;
            1:       first = count;
            2:       first = bmal_pkg::FIELD_W'($urandom_range(0, 16383));
            default: first = bmal_pkg::FIELD_W'($urandom_range(1, count));
          endcase
        end
      endcase
      // last phase runs without sender gaps
      if (p == PHASE_COUNT - 1) gap_pct = 0;
      else gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
      set_config(count, first);
      random_phase(PHASE_ITEMS, count);
      pause_for_drain();
    end

    // nothing outstanding; let a full scan's worth of cycles pass for strays
    repeat (SCAN_CYCLES) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("bitmap_allocator_tb OK");
    end else begin
      $display("bitmap_allocator_tb NOT OK");
    end
    $finish;
  end

endmodule
